// ===== hw/rtl/sdss_pkg.sv =====
`timescale 1ns / 1ps

package sdss_pkg;

  localparam int unsigned NumPositions = 5;
  localparam int unsigned PosWidth     = 3;
  localparam int unsigned SegWidth     = 7;
  localparam int unsigned DigitWidth   = 4;
  localparam int unsigned MagWidth     = 16;

  localparam logic [SegWidth-1:0] SegBlank = 7'h00;
  localparam logic [SegWidth-1:0] SegMinus = 7'h40;

  localparam logic [PosWidth-1:0] PosFirst = 3'd1;
  localparam logic [PosWidth-1:0] PosLast  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SIZE  = 4'b0010,
    ST_DIGIT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // gfedcba glyph of one decimal digit
  function automatic logic [SegWidth-1:0] digit_glyph(input logic [DigitWidth-1:0] d);
    logic [SegWidth-1:0] g;
    begin
      unique case (d)
        4'd0:    g = 7'h3F;
        4'd1:    g = 7'h06;
        4'd2:    g = 7'h5B;
        4'd3:    g = 7'h4F;
        4'd4:    g = 7'h66;
        4'd5:    g = 7'h6D;
        4'd6:    g = 7'h7D;
        4'd7:    g = 7'h07;
        4'd8:    g = 7'h7F;
        4'd9:    g = 7'h6F;
        default: g = SegBlank;
      endcase
      return g;
    end
  endfunction

  // weight of a display position, leftmost first
  function automatic logic [MagWidth-1:0] place_value(input logic [PosWidth-1:0] p);
    logic [MagWidth-1:0] w;
    begin
      unique case (p)
        3'd1:    w = 16'd10000;
        3'd2:    w = 16'd1000;
        3'd3:    w = 16'd100;
        3'd4:    w = 16'd10;
        3'd5:    w = 16'd1;
        default: w = 16'd1;
      endcase
      return w;
    end
  endfunction

endpackage

// ===== hw/rtl/signed_decimal_seven_segment_scan.sv =====
`timescale 1ns / 1ps

// Signed decimal scan for a five-digit seven-segment display. Each input beat
// carries one signed 16-bit value; the block answers with five output beats,
// positions 1 (leftmost) to 5 (units), each with its gfedcba pattern, tlast on
// the fifth. The value is right-aligned with blank leading positions and a minus
// just left of the first digit; values needing more than five positions
// (-10000 and below) show a minus in every position. Digits come from one shared
// 16-bit compare/subtract unit that takes off the place value once per cycle.
// s_tready is low until the fifth beat is taken.
module signed_decimal_seven_segment_scan
  import sdss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] position, [9:3] segment_pattern, [15:10] zero
  output logic        m_tlast    // last_position
);

  state_t                state;
  logic                  neg;
  logic [MagWidth-1:0]   rem;
  logic [PosWidth-1:0]   pos;
  logic [DigitWidth-1:0] digit;
  logic [PosWidth-1:0]   used;
  logic [SegWidth-1:0]   pattern;

  logic [MagWidth-1:0]   mag_in;
  logic [PosWidth-1:0]   width_dec;
  logic [MagWidth-1:0]   place;
  logic                  take;
  logic [SegWidth-1:0]   pattern_next;

  assign mag_in = s_tdata[15] ? (~s_tdata + 16'd1) : s_tdata;

  always_comb begin
    if (rem >= 16'd10000)     width_dec = 3'd5;
    else if (rem >= 16'd1000) width_dec = 3'd4;
    else if (rem >= 16'd100)  width_dec = 3'd3;
    else if (rem >= 16'd10)   width_dec = 3'd2;
    else                      width_dec = 3'd1;
  end

  assign place = place_value(pos);
  assign take  = (rem >= place);

  // leading positions left of the sign are blank, then the minus and the digits; too-wide values show all minus
  always_comb begin
    if (used > PosLast) begin
      pattern_next = SegMinus;
    end else if (pos <= PosLast - used) begin
      pattern_next = SegBlank;
    end else if (neg && (pos == PosLast - used + PosFirst)) begin
      pattern_next = SegMinus;
    end else begin
      pattern_next = digit_glyph(digit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          state <= ST_DIGIT;
        end
        ST_DIGIT: begin
          if (!take) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            state <= (pos == PosLast) ? ST_IDLE : ST_DIGIT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        neg   <= s_tdata[15];
        rem   <= mag_in;
        pos   <= PosFirst;
        digit <= '0;
      end
      ST_SIZE: begin
        used <= width_dec + {{(PosWidth-1){1'b0}}, neg};
      end
      ST_DIGIT: begin
        if (take) begin
          rem   <= rem - place;
          digit <= digit + 4'd1;
        end else begin
          pattern <= pattern_next;
        end
      end
      ST_EMIT: begin
        if (m_tready) begin
          pos   <= pos + 3'd1;
          digit <= '0;
        end
      end
      default: ;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tdata  = {6'd0, pattern, pos};
  assign m_tlast  = (pos == PosLast);

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIGIT) |-> (digit <= 4'd9))
    else $error("digit count ran past nine");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pos >= PosFirst && pos <= PosLast))
    else $error("position out of range on output");

  a_first_pos: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (pos == PosFirst && state == ST_SIZE))
    else $error("item did not start at the first position");
`endif

endmodule

// ===== bench/tb_signed_decimal_seven_segment_scan.sv =====
`timescale 1ns / 1ps

module tb_signed_decimal_seven_segment_scan;
  import sdss_pkg::*;

  localparam int unsigned StallLimit = 1500;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [PosWidth-1:0] position;
    logic [SegWidth-1:0] pattern;
    logic                last;
  } scan_beat_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_CHOKE
  } sink_mode_t;

  localparam logic [SegWidth-1:0] Glyph [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };
  localparam int unsigned Weight [NumPositions] = '{10000, 1000, 100, 10, 1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  scan_beat_t  expected_scan[$];
  int unsigned scan_errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  sink_mode_t  sink_mode = SINK_OPEN;
  int unsigned sink_tick = 0;
  int unsigned choke_left = 0;

  signed_decimal_seven_segment_scan dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // five display beats for one value, leftmost position first
  function automatic void predict_scan(input logic [15:0] raw);
    logic        neg;
    int unsigned mag;
    int unsigned digits;
    int unsigned used;
    int unsigned rest;
    scan_beat_t  beat;
    neg = raw[15];
    mag = neg ? (32'h10000 - int'(raw)) : int'(raw);
    digits = 1;
    rest = mag;
    while (rest >= 10) begin
      rest = rest / 10;
      digits++;
    end
    used = digits + (neg ? 1 : 0);
    for (int unsigned p = 1; p <= NumPositions; p++) begin
      beat.position = PosWidth'(p);
      beat.last = (p == NumPositions);
      if (used > NumPositions) begin
        beat.pattern = SegMinus;
      end else if (p <= NumPositions - used) begin
        beat.pattern = SegBlank;
      end else if (neg && p == NumPositions + 1 - used) begin
        beat.pattern = SegMinus;
      end else begin
        beat.pattern = Glyph[(mag / Weight[p-1]) % 10];
      end
      expected_scan.push_back(beat);
    end
  endfunction

  // output check first, then queue up the new value's beats
  always @(posedge clk) begin
    scan_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_scan.size() == 0) begin
        $error("unexpected beat: position %0d pattern %h last %0b",
               m_tdata[2:0], m_tdata[9:3], m_tlast);
        scan_errors++;
      end else begin
        want = expected_scan.pop_front();
        if (m_tdata[2:0] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, m_tdata[2:0]);
          scan_errors++;
        end
        if (m_tdata[9:3] !== want.pattern) begin
          $error("segment_pattern: expected %h, got %h", want.pattern, m_tdata[9:3]);
          scan_errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_position: expected %0b, got %0b", want.last, m_tlast);
          scan_errors++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) predict_scan(s_tdata);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sink backpressure: open stretches, coin flips and long chokes
  always @(negedge clk) begin
    sink_tick++;
    if (sink_tick % 80 == 0) sink_mode = sink_mode_t'($urandom_range(0, 2));
    case (sink_mode)
      SINK_OPEN: begin
        m_tready <= 1'b1;
      end
      SINK_COIN: begin
        m_tready <= $urandom_range(0, 1);
      end
      default: begin
        if (choke_left > 0) begin
          choke_left--;
          m_tready <= 1'b0;
        end else begin
          choke_left = $urandom_range(0, 10);
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_value(input logic [15:0] v);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic hold_off(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata <= 16'($urandom);
    end
  endtask

  // sender in bursts, with a stretch of no gaps now and then
  task automatic send_bursty(input logic [15:0] v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
    end
    burst_left--;
    send_value(v);
  endtask

  task automatic wait_scan_drained();
    hold_off(1);
    while (expected_scan.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    int unsigned span;
    int          mag;
    span = $urandom_range(0, 9);
    if (span == 9) return 16'($urandom);
    if (span == 8) return 16'(-$urandom_range(10000, 32768));
    mag = $urandom_range(0, 9999);
    case ($urandom_range(0, 3))
      0: mag = mag % 10;
      1: mag = mag % 100;
      2: mag = mag % 1000;
      default: ;
    endcase
    return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
  endfunction

  // extremes, sign placement at every width, and the too-wide range
  task automatic test_directed();
    int vals [$] = '{0, 1, -1, 9, -9, 10, -10, 99, -99, 100, -100, 1234, -1234,
                     9999, -9999, 10000, -10000, -10001, 12345, 30000, 32767,
                     -32768, 5678, 80808, 90};
    foreach (vals[i]) send_value(16'(vals[i]));
  endtask

  task automatic test_drain_pause();
    send_value(16'd7);
    send_value(-16'sd4321);
    wait_scan_drained();
    send_value(16'd24680);
  endtask

  task automatic test_random();
    for (int i = 0; i < 92; i++) begin
      send_bursty(pick_value());
      if (i % 40 == 39) wait_scan_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_drain_pause();
    test_random();
    hold_off(1);
    while (expected_scan.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (scan_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
